[design/gsgs_pkg.sv]
// ----------------------------------------------------------------------------
// gsgs_pkg
// Shared types and constants for the gradient split gain search block.
// ----------------------------------------------------------------------------
package gsgs_pkg;

  localparam int FEAT_W  = 32;
  localparam int GRAD_W  = 32;
  localparam int HESS_W  = 31;
  localparam int SUM_W   = 48;
  localparam int TG_W    = 48;
  localparam int TH_W    = 47;
  localparam int LAM_W   = 31;
  localparam int CFG_W   = 48;
  localparam int CFG_IW  = 2;
  localparam int MAG_W   = 49;
  localparam int DEN_W   = 50;
  localparam int HALF_W  = 25;
  localparam int PP_W    = 2 * HALF_W;
  localparam int PROD_W  = 97;
  localparam int ACC_W   = 100;

  localparam logic [CFG_IW-1:0] CFG_TOTAL_GRADIENT = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_TOTAL_HESSIAN  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_L2_LAMBDA      = 2'd2;

  typedef enum logic [1:0] {
    JOB_FIRST,
    JOB_PLAIN,
    JOB_SPLIT
  } job_kind_t;

  typedef enum logic [1:0] {
    TERM_LEFT,
    TERM_RIGHT,
    TERM_PARENT
  } term_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SETUP,
    B_MUL,
    B_DIV,
    B_ACC,
    B_DECIDE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    job_kind_t                kind;
    logic                     last;
    logic        [SUM_W-1:0]  gl;
    logic        [SUM_W-1:0]  hl;
    logic signed [FEAT_W-1:0] thr;
  } job_t;

endpackage

[design/gsgs_fifo.sv]
// ----------------------------------------------------------------------------
// gsgs_fifo
// Two-entry queue that holds classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module gsgs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gsgs_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output gsgs_pkg::job_t head_job
);
  import gsgs_pkg::*;

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head_job  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

[design/gsgs_front.sv]
// ----------------------------------------------------------------------------
// gsgs_front
// Accepts samples, keeps the running left sums and classifies each sample as
// the first of a batch, a plain sample or a feature boundary to be scored.
// ----------------------------------------------------------------------------
module gsgs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic signed [gsgs_pkg::FEAT_W-1:0]   feature_value,
  input  logic signed [gsgs_pkg::GRAD_W-1:0]   gradient,
  input  logic        [gsgs_pkg::HESS_W-1:0]   hessian,
  input  logic                                 last_sample,
  input  logic                                 queue_full,
  output logic                                 push,
  output gsgs_pkg::job_t                       job
);
  import gsgs_pkg::*;

  logic signed [FEAT_W-1:0] previous_feature;
  logic        [SUM_W-1:0]  left_gradient_sum;
  logic        [SUM_W-1:0]  left_hessian_sum;
  logic                     batch_started;
  logic signed [FEAT_W:0]   mid_sum;

  assign push    = in_valid && !queue_full;
  assign mid_sum = {previous_feature[FEAT_W-1], previous_feature}
                 + {feature_value[FEAT_W-1], feature_value};

  always_comb begin
    job.last = last_sample;
    job.gl   = left_gradient_sum;
    job.hl   = left_hessian_sum;
    if (!batch_started) begin
      job.kind = JOB_FIRST;
      job.thr  = feature_value;
    end else if (feature_value != previous_feature) begin
      job.kind = JOB_SPLIT;
      job.thr  = mid_sum[FEAT_W:1];
    end else begin
      job.kind = JOB_PLAIN;
      job.thr  = mid_sum[FEAT_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_feature  <= '0;
      left_gradient_sum <= '0;
      left_hessian_sum  <= '0;
      batch_started     <= 1'b0;
    end else if (push) begin
      if (last_sample) begin
        previous_feature  <= '0;
        left_gradient_sum <= '0;
        left_hessian_sum  <= '0;
        batch_started     <= 1'b0;
      end else begin
        previous_feature  <= feature_value;
        left_gradient_sum <= left_gradient_sum
                           + {{(SUM_W-GRAD_W){gradient[GRAD_W-1]}}, gradient};
        left_hessian_sum  <= left_hessian_sum + {{(SUM_W-HESS_W){1'b0}}, hessian};
        batch_started     <= 1'b1;
      end
    end
  end

endmodule

[design/gsgs_back.sv]
// ----------------------------------------------------------------------------
// gsgs_back
// Scores feature boundaries with a shared split multiplier and a restoring
// divider, tracks the best split and presents the result of each batch.
// ----------------------------------------------------------------------------
module gsgs_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic signed [gsgs_pkg::TG_W-1:0]     total_gradient,
  input  logic        [gsgs_pkg::TH_W-1:0]     total_hessian,
  input  logic        [gsgs_pkg::LAM_W-1:0]    l2_lambda,
  input  logic                                 cfg_write,
  input  logic                                 job_ready,
  input  gsgs_pkg::job_t                       head_job,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gsgs_pkg::FEAT_W-1:0]   split_threshold,
  output logic signed [63:0]                   split_gain
);
  import gsgs_pkg::*;

  back_state_t state;
  back_state_t state_next;

  job_t                     job;
  term_t                    term_sel;
  logic        [2:0]        mul_cnt;
  logic        [6:0]        div_cnt;
  logic        [MAG_W-1:0]  g_mag;
  logic        [DEN_W-1:0]  d_mag;
  logic                     d_neg;
  logic        [PP_W-1:0]   pp;
  logic        [1:0]        pp_shift;
  logic        [PROD_W-1:0] num;
  logic        [DEN_W-1:0]  rem;
  logic signed [ACC_W-1:0]  sum;
  logic signed [ACC_W-1:0]  parent_term;
  logic                     parent_valid;
  logic signed [FEAT_W-1:0] best_threshold;
  logic signed [63:0]       best_gain;

  logic signed [MAG_W-1:0]  g_sel;
  logic signed [DEN_W-1:0]  d_sel;
  logic        [HALF_W-1:0] mul_x;
  logic        [HALF_W-1:0] mul_y;
  logic        [1:0]        mul_sh;
  logic        [PROD_W-1:0] pp_ext;
  logic        [DEN_W:0]    rs;
  logic                     ge;
  logic signed [ACC_W-1:0]  term_val;
  logic signed [ACC_W-1:0]  diff;
  logic signed [63:0]       gain_sat;
  logic                     can_emit;

  assign can_emit = !out_valid || !out_stall;
  assign pop      = (state == B_IDLE) && job_ready;

  always_comb begin
    case (term_sel)
      TERM_LEFT: begin
        g_sel = {job.gl[SUM_W-1], job.gl};
        d_sel = {2'b00, job.hl} + {{(DEN_W-LAM_W){1'b0}}, l2_lambda};
      end
      TERM_RIGHT: begin
        g_sel = {total_gradient[TG_W-1], total_gradient} - {job.gl[SUM_W-1], job.gl};
        d_sel = {{(DEN_W-TH_W){1'b0}}, total_hessian} - {2'b00, job.hl}
              + {{(DEN_W-LAM_W){1'b0}}, l2_lambda};
      end
      default: begin
        g_sel = {total_gradient[TG_W-1], total_gradient};
        d_sel = {{(DEN_W-TH_W){1'b0}}, total_hessian}
              + {{(DEN_W-LAM_W){1'b0}}, l2_lambda};
      end
    endcase
  end

  always_comb begin
    case (mul_cnt)
      3'd0: begin
        mul_x = g_mag[HALF_W-1:0];
        mul_y = g_mag[HALF_W-1:0];
        mul_sh = 2'd0;
      end
      3'd1: begin
        mul_x = g_mag[HALF_W-1:0];
        mul_y = {1'b0, g_mag[MAG_W-1:HALF_W]};
        mul_sh = 2'd1;
      end
      3'd2: begin
        mul_x = {1'b0, g_mag[MAG_W-1:HALF_W]};
        mul_y = g_mag[HALF_W-1:0];
        mul_sh = 2'd1;
      end
      default: begin
        mul_x = {1'b0, g_mag[MAG_W-1:HALF_W]};
        mul_y = {1'b0, g_mag[MAG_W-1:HALF_W]};
        mul_sh = 2'd2;
      end
    endcase
  end

  always_comb begin
    case (pp_shift)
      2'd0:    pp_ext = PROD_W'(pp);
      2'd1:    pp_ext = PROD_W'(pp) << HALF_W;
      default: pp_ext = PROD_W'(pp) << (2 * HALF_W);
    endcase
  end

  assign rs       = {rem, num[PROD_W-1]};
  assign ge       = rs >= {1'b0, d_mag};
  assign term_val = d_neg ? -$signed({{(ACC_W-PROD_W){1'b0}}, num})
                          :  $signed({{(ACC_W-PROD_W){1'b0}}, num});
  assign diff     = sum - parent_term;

  always_comb begin
    if (diff[ACC_W-1:63] == '0 || diff[ACC_W-1:63] == '1) begin
      gain_sat = diff[63:0];
    end else if (diff[ACC_W-1]) begin
      gain_sat = {1'b1, 63'd0};
    end else begin
      gain_sat = {1'b0, {63{1'b1}}};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (job_ready) begin
          if (head_job.kind == JOB_SPLIT) begin
            state_next = B_SETUP;
          end else if (head_job.last) begin
            state_next = B_EMIT;
          end
        end
      end
      B_SETUP: begin
        state_next = (d_sel == '0) ? B_ACC : B_MUL;
      end
      B_MUL: begin
        if (mul_cnt == 3'd4) begin
          state_next = B_DIV;
        end
      end
      B_DIV: begin
        if (div_cnt == 7'(PROD_W - 1)) begin
          state_next = B_ACC;
        end
      end
      B_ACC: begin
        if (term_sel == TERM_PARENT) begin
          state_next = B_DECIDE;
        end else if (term_sel == TERM_RIGHT && parent_valid) begin
          state_next = B_DECIDE;
        end else begin
          state_next = B_SETUP;
        end
      end
      B_DECIDE: begin
        state_next = job.last ? B_EMIT : B_IDLE;
      end
      B_EMIT: begin
        if (can_emit) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_ready) begin
          job      <= head_job;
          term_sel <= TERM_LEFT;
          sum      <= '0;
        end
      end
      B_SETUP: begin
        g_mag   <= g_sel[MAG_W-1] ? MAG_W'(-g_sel) : MAG_W'(g_sel);
        d_mag   <= d_sel[DEN_W-1] ? DEN_W'(-d_sel) : DEN_W'(d_sel);
        d_neg   <= d_sel[DEN_W-1];
        num     <= '0;
        mul_cnt <= '0;
      end
      B_MUL: begin
        if (mul_cnt != 3'd4) begin
          pp       <= mul_x * mul_y;
          pp_shift <= mul_sh;
        end
        if (mul_cnt != 3'd0) begin
          num <= num + pp_ext;
        end
        mul_cnt <= mul_cnt + 3'd1;
        rem     <= '0;
        div_cnt <= '0;
      end
      B_DIV: begin
        rem     <= ge ? DEN_W'(rs - {1'b0, d_mag}) : rs[DEN_W-1:0];
        num     <= {num[PROD_W-2:0], ge};
        div_cnt <= div_cnt + 7'd1;
      end
      B_ACC: begin
        if (term_sel == TERM_PARENT) begin
          parent_term <= term_val;
        end else begin
          sum <= sum + term_val;
        end
        term_sel <= (term_sel == TERM_LEFT) ? TERM_RIGHT : TERM_PARENT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parent_valid   <= 1'b0;
      best_threshold <= '0;
      best_gain      <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (state == B_EMIT && can_emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write || (state == B_EMIT && can_emit)) begin
        parent_valid <= 1'b0;
      end else if (state == B_ACC && term_sel == TERM_PARENT) begin
        parent_valid <= 1'b1;
      end
      case (state)
        B_IDLE: begin
          if (job_ready && head_job.kind == JOB_FIRST) begin
            best_threshold <= head_job.thr;
            best_gain      <= '0;
          end
        end
        B_DECIDE: begin
          if (gain_sat > best_gain) begin
            best_gain      <= gain_sat;
            best_threshold <= job.thr;
          end
        end
        B_EMIT: begin
          if (can_emit) begin
            split_threshold <= best_threshold;
            split_gain      <= best_gain;
            best_threshold  <= '0;
            best_gain       <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/gradient_split_gain_search.sv]
// ----------------------------------------------------------------------------
// gradient_split_gain_search
// Exact split gain search over samples in ascending feature order.
// ----------------------------------------------------------------------------
// A sample that does not start a new feature value is not scored. A sample at
// a feature boundary is scored in steps: the job is taken, the left and right
// terms are each built by a setup step, the partial products of the shared
// multiplier, the restoring divider that makes one quotient bit a cycle and
// an accumulate step, and the gain is then compared. A term whose denominator
// is zero skips the multiplier and divider. The first boundary of a batch,
// and the first after a register write, also scores the parent term, which is
// then held until the batch ends. The last sample of a batch passes an emit
// state that hands the result to the output register. A two-entry queue lets
// the front end take samples while the back end is busy, and the result of a
// batch waits in an output register.
module gradient_split_gain_search (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write_enable,
  input  logic        [gsgs_pkg::CFG_IW-1:0]   cfg_index,
  input  logic        [gsgs_pkg::CFG_W-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [gsgs_pkg::FEAT_W-1:0]   feature_value,
  input  logic signed [gsgs_pkg::GRAD_W-1:0]   gradient,
  input  logic        [gsgs_pkg::HESS_W-1:0]   hessian,
  input  logic                                 last_sample,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [gsgs_pkg::FEAT_W-1:0]   split_threshold,
  output logic signed [63:0]                   split_gain
);
  import gsgs_pkg::*;

  logic signed [TG_W-1:0]  total_gradient;
  logic        [TH_W-1:0]  total_hessian;
  logic        [LAM_W-1:0] l2_lambda;

  logic queue_full;
  logic queue_not_empty;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  assign in_stall = queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_gradient <= '0;
      total_hessian  <= '0;
      l2_lambda      <= '0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        CFG_TOTAL_GRADIENT: total_gradient <= cfg_data[TG_W-1:0];
        CFG_TOTAL_HESSIAN:  total_hessian  <= cfg_data[TH_W-1:0];
        CFG_L2_LAMBDA:      l2_lambda      <= cfg_data[LAM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gsgs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .feature_value (feature_value),
    .gradient      (gradient),
    .hessian       (hessian),
    .last_sample   (last_sample),
    .queue_full    (queue_full),
    .push          (push),
    .job           (push_job)
  );

  gsgs_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_job  (head_job)
  );

  gsgs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .total_gradient  (total_gradient),
    .total_hessian   (total_hessian),
    .l2_lambda       (l2_lambda),
    .cfg_write       (cfg_write_enable),
    .job_ready       (queue_not_empty),
    .head_job        (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .split_threshold (split_threshold),
    .split_gain      (split_gain)
  );

endmodule
